/* rtl/gdda_pkg.sv */
`default_nettype none

package gdda_pkg;

   // Field widths of the item and result channels.
   localparam int unsigned POS_W  = 6;
   localparam int unsigned KIND_W = 3;
   localparam int unsigned DIR_W  = 16;

   // Operation codes carried by the func field.
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_CAST  = 1'b1;

   // Delta distances are unsigned Q8.16 reciprocals of a Q1.14 magnitude.
   localparam int unsigned DELTA_W = 24;
   localparam logic [DELTA_W-1:0] DELTA_MAX = {DELTA_W{1'b1}};

   // Any magnitude at or below this value gives a quotient of 2^24 or more,
   // so the delta saturates.
   localparam int unsigned SAT_MAG = 64;

   // Partial remainder of 2^30 after its seven leading quotient bits, which
   // are all zero whenever the magnitude is above the saturation limit.
   localparam int unsigned REM_INIT = 64;

   localparam logic [KIND_W-1:0] KIND_EMPTY = '0;

endpackage

`default_nettype wire

/* rtl/grid_dda_ray_traversal_core.sv */
`default_nettype none

// Grid ray traversal core.
// The block keeps a GRID_W by GRID_H map of 3-bit cell kinds, where kind 0 is
// an empty cell. An item is offered on the req_ ports with start high and is
// taken at a clock edge where busy is low. A write item (func 0) stores one
// cell, leaves busy low and gives no result; writes outside
// the map are dropped. A cast item (func 1) walks from its start cell along the
// direction given in Q1.14 until it reaches a non-empty cell or leaves the map,
// and gives exactly one result, shown on the rsp_ ports for one cycle with
// rsp_strobe high. The receiver cannot hold results off.
//
// A cast first forms both delta distances in one shared restoring divider,
// one quotient bit a cycle. The walk then steps through the cells one at a
// time, since the map memory has one registered read port and each step
// issues one read. For a cast that starts inside the map, busy is high from
// the edge that accepts it until the edge that gives its result. A cast whose
// start cell lies outside the map answers in the next cycle.
//
// Reset clears the sequencer and the divider control only. The map contents
// are not cleared and must be written before any cast reads them.
module grid_dda_ray_traversal_core #(
   parameter int unsigned GRID_W = 64,
   parameter int unsigned GRID_H = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic                                 req_func,
   input  wire logic        [gdda_pkg::POS_W-1:0]    req_pos_x,
   input  wire logic        [gdda_pkg::POS_W-1:0]    req_pos_y,
   input  wire logic        [gdda_pkg::KIND_W-1:0]   req_cell_kind,
   input  wire logic signed [gdda_pkg::DIR_W-1:0]    req_dir_x,
   input  wire logic signed [gdda_pkg::DIR_W-1:0]    req_dir_y,
   output logic                                      rsp_strobe,
   output logic             [gdda_pkg::KIND_W-1:0]   rsp_hit_kind,
   output logic             [gdda_pkg::POS_W-1:0]    rsp_hit_x,
   output logic             [gdda_pkg::POS_W-1:0]    rsp_hit_y,
   output logic                                      rsp_out_of_map
);

   // Coordinates carry one bit above the wider of the widest axis and the
   // position field, so a step below zero wraps to a value that fails the same
   // unsigned bound check as a step past the far edge.
   localparam int unsigned AXIS_BITS = ($clog2(GRID_W) > $clog2(GRID_H)) ?
                                       $clog2(GRID_W) : $clog2(GRID_H);
   localparam int unsigned CW = ((AXIS_BITS > gdda_pkg::POS_W) ?
                                 AXIS_BITS : gdda_pkg::POS_W) + 1;
   localparam int unsigned DEPTH = GRID_W * GRID_H;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned PW    = AW + CW;
   // Side distances grow by at most one delta per step and an axis sees at
   // most its size plus one delta in total.
   localparam int unsigned SW    = gdda_pkg::DELTA_W + AXIS_BITS + 2;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIVX = 2'd1;
   localparam logic [1:0] ST_DIVY = 2'd2;
   localparam logic [1:0] ST_WALK = 2'd3;

   logic [1:0]                        state_ff;
   logic [CW-1:0]                     cx_ff;
   logic [CW-1:0]                     cy_ff;
   logic                              negx_ff;
   logic                              negy_ff;
   logic signed [gdda_pkg::DIR_W-1:0] diry_ff;
   logic [gdda_pkg::DELTA_W-1:0]      dx_ff;
   logic [gdda_pkg::DELTA_W-1:0]      dy_ff;
   logic [SW-1:0]                     sx_ff;
   logic [SW-1:0]                     sy_ff;
   logic                              pend_ff;

   logic                              rsp_strobe_ff;
   logic [gdda_pkg::KIND_W-1:0]       rsp_kind_ff;
   logic [gdda_pkg::POS_W-1:0]        rsp_x_ff;
   logic [gdda_pkg::POS_W-1:0]        rsp_y_ff;
   logic                              rsp_oom_ff;

   logic                              accept;
   logic [CW-1:0]                     req_x_wide;
   logic [CW-1:0]                     req_y_wide;
   logic                              req_in_map;
   logic                              wr_en;
   logic [PW-1:0]                     wr_addr_full;

   logic                              recip_start;
   logic signed [gdda_pkg::DIR_W-1:0] recip_dir;
   logic                              recip_done;
   logic [gdda_pkg::DELTA_W-1:0]      recip_quot;

   logic                              take_x;
   logic [CW-1:0]                     cx_step;
   logic [CW-1:0]                     cy_step;
   logic [CW-1:0]                     nx_in;
   logic [CW-1:0]                     ny_in;
   logic [SW-1:0]                     sx_in;
   logic [SW-1:0]                     sy_in;
   logic                              step_out;
   logic [PW-1:0]                     rd_addr_full;
   logic [gdda_pkg::KIND_W-1:0]       rd_kind;
   logic                              hit;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign req_x_wide = CW'(req_pos_x);
   assign req_y_wide = CW'(req_pos_y);
   assign req_in_map = (req_x_wide < CW'(GRID_W)) && (req_y_wide < CW'(GRID_H));

   // Writes go straight into the map in the cycle they are taken.
   assign wr_en        = accept && (req_func == gdda_pkg::FUNC_WRITE) && req_in_map;
   assign wr_addr_full = PW'(req_y_wide) * PW'(GRID_W) + PW'(req_x_wide);

   // The divider serves the x axis first and then the y axis.
   assign recip_start = (accept && (req_func == gdda_pkg::FUNC_CAST) && req_in_map) ||
                        ((state_ff == ST_DIVX) && recip_done);
   assign recip_dir   = (state_ff == ST_IDLE) ? req_dir_x : diry_ff;

   gdda_recip u_recip (
      .clock (clock),
      .reset (reset),
      .start (recip_start),
      .dir   (recip_dir),
      .done  (recip_done),
      .quot  (recip_quot)
   );

   // One DDA step: move along x when its side distance is strictly smaller.
   assign take_x  = (sx_ff < sy_ff);
   assign cx_step = cx_ff + (negx_ff ? {CW{1'b1}} : CW'(1));
   assign cy_step = cy_ff + (negy_ff ? {CW{1'b1}} : CW'(1));
   assign nx_in   = take_x ? cx_step : cx_ff;
   assign ny_in   = take_x ? cy_ff : cy_step;
   assign sx_in   = take_x ? (sx_ff + SW'(dx_ff)) : sx_ff;
   assign sy_in   = take_x ? sy_ff : (sy_ff + SW'(dy_ff));
   assign step_out = (nx_in >= CW'(GRID_W)) || (ny_in >= CW'(GRID_H));

   assign rd_addr_full = PW'(ny_in) * PW'(GRID_W) + PW'(nx_in);

   gdda_ram #(
      .WIDTH (gdda_pkg::KIND_W),
      .DEPTH (DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr_full[AW-1:0]),
      .wr_data (req_cell_kind),
      .rd_addr (rd_addr_full[AW-1:0]),
      .rd_data (rd_kind)
   );

   // The read issued in the previous cycle belongs to the current cell. The
   // next step is computed alongside it and is simply dropped on a hit.
   assign hit = pend_ff && (rd_kind != gdda_pkg::KIND_EMPTY);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept && (req_func == gdda_pkg::FUNC_CAST)) begin
                  if (req_in_map) begin
                     state_ff <= ST_DIVX;
                  end else begin
                     rsp_strobe_ff <= 1'b1;
                  end
               end
            end
            ST_DIVX: begin
               if (recip_done) begin
                  state_ff <= ST_DIVY;
               end
            end
            ST_DIVY: begin
               if (recip_done) begin
                  state_ff <= ST_WALK;
                  pend_ff  <= 1'b0;
               end
            end
            ST_WALK: begin
               if (hit || step_out) begin
                  state_ff      <= ST_IDLE;
                  pend_ff       <= 1'b0;
                  rsp_strobe_ff <= 1'b1;
               end else begin
                  pend_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               pend_ff  <= 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            cx_ff   <= req_x_wide;
            cy_ff   <= req_y_wide;
            negx_ff <= req_dir_x[gdda_pkg::DIR_W-1];
            negy_ff <= req_dir_y[gdda_pkg::DIR_W-1];
            diry_ff <= req_dir_y;
            rsp_kind_ff <= '0;
            rsp_x_ff    <= '0;
            rsp_y_ff    <= '0;
            rsp_oom_ff  <= 1'b1;
         end
         ST_DIVX: begin
            if (recip_done) begin
               dx_ff <= recip_quot;
               sx_ff <= negx_ff ? '0 : SW'(recip_quot);
            end
         end
         ST_DIVY: begin
            if (recip_done) begin
               dy_ff <= recip_quot;
               sy_ff <= negy_ff ? '0 : SW'(recip_quot);
            end
         end
         ST_WALK: begin
            if (hit) begin
               rsp_kind_ff <= rd_kind;
               rsp_x_ff    <= cx_ff[gdda_pkg::POS_W-1:0];
               rsp_y_ff    <= cy_ff[gdda_pkg::POS_W-1:0];
               rsp_oom_ff  <= 1'b0;
            end else if (step_out) begin
               rsp_kind_ff <= '0;
               rsp_x_ff    <= '0;
               rsp_y_ff    <= '0;
               rsp_oom_ff  <= 1'b1;
            end else begin
               cx_ff <= nx_in;
               cy_ff <= ny_in;
               sx_ff <= sx_in;
               sy_ff <= sy_in;
            end
         end
         default: begin
            rsp_oom_ff <= 1'b1;
         end
      endcase
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_hit_kind   = rsp_kind_ff;
   assign rsp_hit_x      = rsp_x_ff;
   assign rsp_hit_y      = rsp_y_ff;
   assign rsp_out_of_map = rsp_oom_ff;

   // A result follows either a finished walk or a cast that starts off the map.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_WALK) ||
                     ($past(accept) && ($past(req_func) == gdda_pkg::FUNC_CAST)))
      else $error("result without a finished cast");

   // A ray that leaves the map reports no cell.
   a_oom_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_out_of_map) |->
         (rsp_hit_kind == gdda_pkg::KIND_EMPTY) && (rsp_hit_x == '0) && (rsp_hit_y == '0))
      else $error("out-of-map result carries a cell");

   // A hit always names a non-empty cell.
   a_hit_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_out_of_map) |-> (rsp_hit_kind != gdda_pkg::KIND_EMPTY))
      else $error("hit reports an empty cell");

   // The cell whose read is pending lies inside the map.
   a_walk_in_map: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WALK) && pend_ff) |->
         (cx_ff < CW'(GRID_W)) && (cy_ff < CW'(GRID_H)))
      else $error("walk position outside the map");

   // The divider finishes only while the sequencer waits for it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      recip_done |-> (state_ff == ST_DIVX) || (state_ff == ST_DIVY))
      else $error("divider result outside a divide phase");

endmodule

`default_nettype wire

/* rtl/gdda_ram.sv */
`default_nettype none

module gdda_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/gdda_recip.sv */
`default_nettype none

module gdda_recip (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [gdda_pkg::DIR_W-1:0]   dir,
   output logic                                     done,
   output logic             [gdda_pkg::DELTA_W-1:0] quot
);

   localparam int unsigned MAG_W = gdda_pkg::DIR_W;
   localparam int unsigned REM_W = MAG_W + 1;
   localparam int unsigned CNT_W = $clog2(gdda_pkg::DELTA_W + 1);

   logic [MAG_W-1:0]              mag_in;
   logic                          sat_in;
   logic [MAG_W-1:0]              mag_ff;
   logic                          sat_ff;
   logic [REM_W-1:0]              rem_ff;
   logic [REM_W-1:0]              rem_in;
   logic [REM_W-1:0]              rem_shift;
   logic [gdda_pkg::DELTA_W-1:0]  q_ff;
   logic [gdda_pkg::DELTA_W-1:0]  q_in;
   logic [CNT_W-1:0]              cnt_ff;
   logic                          run_ff;
   logic                          done_ff;
   logic                          fits;

   // Magnitude of a two's complement value; the most negative code maps to 2^15.
   assign mag_in = dir[gdda_pkg::DIR_W-1] ? (~$unsigned(dir) + MAG_W'(1)) : $unsigned(dir);
   assign sat_in = (mag_in <= MAG_W'(gdda_pkg::SAT_MAG));

   // One restoring step: shift in a zero dividend bit, subtract when it fits.
   assign rem_shift = {rem_ff[REM_W-2:0], 1'b0};
   assign fits      = (rem_shift >= {1'b0, mag_ff});
   assign rem_in    = fits ? (rem_shift - {1'b0, mag_ff}) : rem_shift;
   assign q_in      = {q_ff[gdda_pkg::DELTA_W-2:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(gdda_pkg::DELTA_W);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mag_ff <= mag_in;
         sat_ff <= sat_in;
         rem_ff <= REM_W'(gdda_pkg::REM_INIT);
         q_ff   <= '0;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

   assign done = done_ff;
   assign quot = sat_ff ? gdda_pkg::DELTA_MAX : q_ff;

endmodule

`default_nettype wire

/* dv/ray_cast_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the ray traversal core, keeps a shadow copy of the
// map and predicts each cast's result when the cast is accepted.
module ray_cast_checker #(
   parameter int unsigned GRID_W = 64,
   parameter int unsigned GRID_H = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic                                 busy,
   input  wire logic                                 req_func,
   input  wire logic        [gdda_pkg::POS_W-1:0]    req_pos_x,
   input  wire logic        [gdda_pkg::POS_W-1:0]    req_pos_y,
   input  wire logic        [gdda_pkg::KIND_W-1:0]   req_cell_kind,
   input  wire logic signed [gdda_pkg::DIR_W-1:0]    req_dir_x,
   input  wire logic signed [gdda_pkg::DIR_W-1:0]    req_dir_y,
   input  wire logic                                 rsp_strobe,
   input  wire logic        [gdda_pkg::KIND_W-1:0]   rsp_hit_kind,
   input  wire logic        [gdda_pkg::POS_W-1:0]    rsp_hit_x,
   input  wire logic        [gdda_pkg::POS_W-1:0]    rsp_hit_y,
   input  wire logic                                 rsp_out_of_map,
   output int                                        mismatch_count,
   output int                                        casts_outstanding
);

   typedef struct packed {
      logic [gdda_pkg::KIND_W-1:0] kind;
      logic [gdda_pkg::POS_W-1:0]  x;
      logic [gdda_pkg::POS_W-1:0]  y;
      logic                        oom;
   } ray_hit_type;

   logic [gdda_pkg::KIND_W-1:0] map_shadow [GRID_W*GRID_H];
   ray_hit_type                 hits_due [$];
   int                          bad_fields = 0;
   int                          due_count = 0;

   assign mismatch_count    = bad_fields;
   assign casts_outstanding = due_count;

   // Unsigned Q8.16 reciprocal of a Q1.14 magnitude, saturated to 24 bits.
   function automatic logic [gdda_pkg::DELTA_W-1:0] delta_dist(
         logic [gdda_pkg::DIR_W-1:0] dir);
      logic [31:0] mag;
      logic [31:0] quo;
      mag = dir[gdda_pkg::DIR_W-1] ? ((32'd1 << gdda_pkg::DIR_W) - 32'(dir)) : 32'(dir);
      if (mag == 0) return gdda_pkg::DELTA_MAX;
      quo = 32'h4000_0000 / mag;
      if (quo > 32'(gdda_pkg::DELTA_MAX)) return gdda_pkg::DELTA_MAX;
      return quo[gdda_pkg::DELTA_W-1:0];
   endfunction

   // Walks the shadow map from the start cell; the start cell is not tested.
   function automatic ray_hit_type trace_ray(
         logic [gdda_pkg::POS_W-1:0] px, logic [gdda_pkg::POS_W-1:0] py,
         logic [gdda_pkg::DIR_W-1:0] dx, logic [gdda_pkg::DIR_W-1:0] dy);
      ray_hit_type                 res;
      int                          cx;
      int                          cy;
      int                          step_x;
      int                          step_y;
      int                          n;
      logic [63:0]                 side_x;
      logic [63:0]                 side_y;
      logic [63:0]                 dlt_x;
      logic [63:0]                 dlt_y;
      logic [gdda_pkg::KIND_W-1:0] map_kind;
      res     = '0;
      res.oom = 1'b1;
      cx      = int'(px);
      cy      = int'(py);
      if (cx >= int'(GRID_W) || cy >= int'(GRID_H)) return res;
      dlt_x  = 64'(delta_dist(dx));
      dlt_y  = 64'(delta_dist(dy));
      step_x = dx[gdda_pkg::DIR_W-1] ? -1 : 1;
      step_y = dy[gdda_pkg::DIR_W-1] ? -1 : 1;
      side_x = dx[gdda_pkg::DIR_W-1] ? 64'd0 : dlt_x;
      side_y = dy[gdda_pkg::DIR_W-1] ? 64'd0 : dlt_y;
      // Every step moves one cell, so the ray is off the map well within this bound.
      for (n = 0; n < 2 * int'(GRID_W + GRID_H); n++) begin
         if (side_x < side_y) begin
            side_x += dlt_x;
            cx     += step_x;
         end else begin
            side_y += dlt_y;
            cy     += step_y;
         end
         if (cx < 0 || cx >= int'(GRID_W) || cy < 0 || cy >= int'(GRID_H)) return res;
         map_kind = map_shadow[cy * int'(GRID_W) + cx];
         if (map_kind != gdda_pkg::KIND_EMPTY) begin
            res.kind = map_kind;
            res.x    = cx[gdda_pkg::POS_W-1:0];
            res.y    = cy[gdda_pkg::POS_W-1:0];
            res.oom  = 1'b0;
            return res;
         end
      end
      return res;
   endfunction

   task automatic check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         bad_fields++;
      end
   endtask

   always @(posedge clock) begin
      ray_hit_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (hits_due.size() == 0) begin
               $error("result arrived with no cast outstanding");
               bad_fields++;
            end else begin
               want = hits_due.pop_front();
               check_field("hit_kind", want.kind, rsp_hit_kind);
               check_field("hit_x", want.x, rsp_hit_x);
               check_field("hit_y", want.y, rsp_hit_y);
               check_field("out_of_map", want.oom, rsp_out_of_map);
            end
         end
         if (start && !busy) begin
            if (req_func == gdda_pkg::FUNC_CAST)
               hits_due.push_back(trace_ray(req_pos_x, req_pos_y, req_dir_x, req_dir_y));
            else if (req_pos_x < GRID_W && req_pos_y < GRID_H)
               map_shadow[req_pos_y * GRID_W + req_pos_x] = req_cell_kind;
         end
      end
      due_count <= hits_due.size();
   end

endmodule

/* dv/tb_grid_dda_ray_traversal_core.sv */
`timescale 1ns / 1ps

// Top of the ray traversal testbench. This module only makes stimulus and
// gives the verdict; the checker beside the block predicts and compares.
module tb_grid_dda_ray_traversal_core;

   localparam int unsigned GRID_W = 64;
   localparam int unsigned GRID_H = 64;

   // A cast walks at most about 130 cells after its divider setup, so a stall
   // this long with nothing accepted means the block has hung.
   localparam int STALL_LIMIT  = 2000;
   // Cycles allowed after the last result so that a stray extra result shows.
   localparam int DRAIN_CYCLES = 200;
   localparam int RANDOM_ITEMS = 610;

   // Casts start in the top rows of the map only. The row below them is a
   // wall of non-empty cells, so any ray that steps down into it stops there,
   // and the rows further down are never read and never need to be written.
   localparam int BAND_ROWS = 4;
   localparam int WALL_ROW  = BAND_ROWS;

   // Direction values at the corners of the reciprocal: both extremes, the
   // smallest magnitudes, and the boundary where the delta stops saturating.
   localparam logic [gdda_pkg::DIR_W-1:0] EDGE_DIRS [8] = '{
      16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0001, 16'h0040, 16'hFFC0, 16'h0041
   };

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   logic                               req_func = gdda_pkg::FUNC_WRITE;
   logic        [gdda_pkg::POS_W-1:0]  req_pos_x = '0;
   logic        [gdda_pkg::POS_W-1:0]  req_pos_y = '0;
   logic        [gdda_pkg::KIND_W-1:0] req_cell_kind = '0;
   logic signed [gdda_pkg::DIR_W-1:0]  req_dir_x = '0;
   logic signed [gdda_pkg::DIR_W-1:0]  req_dir_y = '0;
   logic                               rsp_strobe;
   logic        [gdda_pkg::KIND_W-1:0] rsp_hit_kind;
   logic        [gdda_pkg::POS_W-1:0]  rsp_hit_x;
   logic        [gdda_pkg::POS_W-1:0]  rsp_hit_y;
   logic                               rsp_out_of_map;
   int                                 mismatch_count;
   int                                 casts_outstanding;
   int                                 quiet_cycles = 0;
   bit                                 steady_run = 1'b0;

   always #4 clock = ~clock;

   grid_dda_ray_traversal_core #(
      .GRID_W (GRID_W),
      .GRID_H (GRID_H)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_cell_kind  (req_cell_kind),
      .req_dir_x      (req_dir_x),
      .req_dir_y      (req_dir_y),
      .rsp_strobe     (rsp_strobe),
      .rsp_hit_kind   (rsp_hit_kind),
      .rsp_hit_x      (rsp_hit_x),
      .rsp_hit_y      (rsp_hit_y),
      .rsp_out_of_map (rsp_out_of_map)
   );

   ray_cast_checker #(
      .GRID_W (GRID_W),
      .GRID_H (GRID_H)
   ) ray_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_cell_kind     (req_cell_kind),
      .req_dir_x         (req_dir_x),
      .req_dir_y         (req_dir_y),
      .rsp_strobe        (rsp_strobe),
      .rsp_hit_kind      (rsp_hit_kind),
      .rsp_hit_x         (rsp_hit_x),
      .rsp_hit_y         (rsp_hit_y),
      .rsp_out_of_map    (rsp_out_of_map),
      .mismatch_count    (mismatch_count),
      .casts_outstanding (casts_outstanding)
   );

   // The watchdog restarts whenever an item is taken or a result comes out.
   // If neither happens until the quiet count reaches STALL_LIMIT, the run ends as a failure.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one item and returns at the edge that accepts it. Before the item
   // the sender may sit idle for a few cycles, unless a steady stretch is on.
   // Busy is read right after the edge, so it still holds the value that
   // decided acceptance at that edge.
   task automatic send_item(input logic func, input int px, input int py, input int kind,
                            input logic [gdda_pkg::DIR_W-1:0] dx,
                            input logic [gdda_pkg::DIR_W-1:0] dy);
      while (!steady_run && $urandom_range(99) < 29) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_func      <= func;
      req_pos_x     <= px[gdda_pkg::POS_W-1:0];
      req_pos_y     <= py[gdda_pkg::POS_W-1:0];
      req_cell_kind <= kind[gdda_pkg::KIND_W-1:0];
      req_dir_x     <= dx;
      req_dir_y     <= dy;
      do @(posedge clock); while (busy);
   endtask

   // Writes every cell of the band and of the wall row below it. A band cell
   // is non-empty with the given percent chance; wall cells are never empty.
   // The direction fields carry noise, since a write ignores them.
   task automatic fill_band(input int density);
      int x;
      int y;
      for (y = 0; y <= WALL_ROW; y++) begin
         for (x = 0; x < int'(GRID_W); x++) begin
            send_item(gdda_pkg::FUNC_WRITE, x, y,
                      (y == WALL_ROW || $urandom_range(99) < density) ?
                         $urandom_range(7, 1) : 0,
                      gdda_pkg::DIR_W'($urandom_range(65535)),
                      gdda_pkg::DIR_W'($urandom_range(65535)));
         end
      end
   endtask

   initial begin
      int                         item_no;
      int                         px;
      int                         py;
      int                         mode;
      int                         tiny;
      logic [gdda_pkg::DIR_W-1:0] dx;
      logic [gdda_pkg::DIR_W-1:0] dy;
      logic [gdda_pkg::DIR_W-1:0] mag;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Every cell a cast can reach is written before the first cast. The
      // band starts empty so that the directed casts below have known paths.
      fill_band(0);

      // A hit on the right edge, then a ray that leaves through the left
      // edge on its very first step.
      send_item(gdda_pkg::FUNC_WRITE, 63, 0, 7, 16'h0000, 16'h0000);
      send_item(gdda_pkg::FUNC_CAST, 0, 0, 0, 16'h7FFF, 16'h0000);
      send_item(gdda_pkg::FUNC_CAST, 0, 2, 3, 16'h8000, 16'h0000);
      // Zero direction: both deltas saturate and the tie rule makes a staircase.
      send_item(gdda_pkg::FUNC_CAST, 0, 0, 6, 16'h0000, 16'h0000);
      // Straight down column 0 to a hit on the wall row.
      send_item(gdda_pkg::FUNC_CAST, 0, 0, 0, 16'h0000, 16'h4000);
      // Tiny negative components, the saturation boundary at magnitude 64,
      // and the first magnitude that no longer saturates.
      send_item(gdda_pkg::FUNC_CAST, 32, 2, 0, 16'hFFFF, 16'hFFFF);
      send_item(gdda_pkg::FUNC_CAST, 32, 2, 0, 16'h0040, 16'hFFC0);
      send_item(gdda_pkg::FUNC_CAST, 32, 2, 0, 16'h0041, 16'hFFBF);
      // Equal side distances step in y first, so the diagonal misses the cell
      // to the right; a shallower ray reaches it.
      send_item(gdda_pkg::FUNC_WRITE, 33, 2, 2, 16'h0000, 16'h0000);
      send_item(gdda_pkg::FUNC_CAST, 32, 2, 0, 16'h4000, 16'h4000);
      send_item(gdda_pkg::FUNC_CAST, 32, 2, 0, 16'h4000, 16'h2000);
      // Negative directions start with zero side distance on both axes.
      send_item(gdda_pkg::FUNC_WRITE, 31, 1, 4, 16'h0000, 16'h0000);
      send_item(gdda_pkg::FUNC_CAST, 32, 2, 0, 16'hC000, 16'hC000);
      // A start on the right edge that leaves at once, a start on a non-empty
      // cell, which is never tested itself, and a near-diagonal ray into the wall.
      send_item(gdda_pkg::FUNC_CAST, 63, 2, 0, 16'h7FFF, 16'h0000);
      send_item(gdda_pkg::FUNC_CAST, 63, 0, 0, 16'h8000, 16'h0000);
      send_item(gdda_pkg::FUNC_CAST, 5, 3, 0, 16'h8000, 16'h7FFF);
      // Clearing a cell lets the same ray run off the right edge.
      send_item(gdda_pkg::FUNC_WRITE, 63, 0, 0, 16'h0000, 16'h0000);
      send_item(gdda_pkg::FUNC_CAST, 0, 0, 0, 16'h7FFF, 16'h0000);
      // A hit in the top-left corner.
      send_item(gdda_pkg::FUNC_WRITE, 0, 0, 5, 16'h0000, 16'h0000);
      send_item(gdda_pkg::FUNC_CAST, 1, 1, 0, 16'hC000, 16'hC000);

      // Random part. Writes keep filling the band under the casts and keep
      // the wall non-empty. A stretch runs with no idle cycles at all.
      for (item_no = 0; item_no < RANDOM_ITEMS; item_no++) begin
         steady_run = (item_no >= 150 && item_no < 260);
         px = $urandom_range(63);
         if ($urandom_range(99) < 35) begin
            py = $urandom_range(WALL_ROW);
            send_item(gdda_pkg::FUNC_WRITE, px, py,
                      (py == WALL_ROW) ? $urandom_range(7, 1) : $urandom_range(7),
                      gdda_pkg::DIR_W'($urandom_range(65535)),
                      gdda_pkg::DIR_W'($urandom_range(65535)));
         end else begin
            py   = $urandom_range(BAND_ROWS - 1);
            mode = $urandom_range(99);
            if (mode < 50) begin
               dx = gdda_pkg::DIR_W'($urandom_range(65535));
               dy = gdda_pkg::DIR_W'($urandom_range(65535));
            end else if (mode < 65) begin
               // Nearly along one axis: the other component is zero or tiny.
               tiny = $urandom_range(130);
               tiny = tiny - 65;
               dx   = gdda_pkg::DIR_W'($urandom_range(65535));
               dy   = tiny[gdda_pkg::DIR_W-1:0];
               if ($urandom_range(1)) begin
                  mag = dx;
                  dx  = dy;
                  dy  = mag;
               end
            end else if (mode < 75) begin
               tiny = $urandom_range(140);
               tiny = tiny - 70;
               dx   = tiny[gdda_pkg::DIR_W-1:0];
               tiny = $urandom_range(140);
               tiny = tiny - 70;
               dy   = tiny[gdda_pkg::DIR_W-1:0];
            end else if (mode < 85) begin
               // Equal magnitudes give ties between the side distances.
               mag = gdda_pkg::DIR_W'($urandom_range(32767, 1));
               dx  = $urandom_range(1) ? -mag : mag;
               dy  = $urandom_range(1) ? -mag : mag;
            end else begin
               dx = EDGE_DIRS[$urandom_range(7)];
               dy = EDGE_DIRS[$urandom_range(7)];
            end
            send_item(gdda_pkg::FUNC_CAST, px, py, $urandom_range(7), dx, dy);
         end
      end
      start <= 1'b0;

      // The checker's count of outstanding casts is updated after the edge
      // that takes an item, so the bench waits for the next edge before reading it.
      @(posedge clock);
      while (casts_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && casts_outstanding == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* sim.f */
rtl/gdda_pkg.sv
rtl/gdda_ram.sv
rtl/gdda_recip.sv
rtl/grid_dda_ray_traversal_core.sv
dv/ray_cast_checker.sv
dv/tb_grid_dda_ray_traversal_core.sv
